>>> src/ufr_pkg.sv
// Package for the UART frame receiver: sizes, codes and derived widths.
package ufr_pkg;

    localparam int SLOT_COUNT      = 3;
    localparam int MAX_FRAME_BYTES = 32;

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int IDX_W   = $clog2(MAX_FRAME_BYTES);
    localparam int DEPTH   = SLOT_COUNT * MAX_FRAME_BYTES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CMP_W   = (POS_W > 6) ? POS_W : 6;

    localparam logic [5:0]  RST_FRAME_LENGTH = 6'd12;
    localparam logic [15:0] RST_IDLE_LIMIT   = 16'd300;
    localparam logic [7:0]  RST_SYNC_VALUE   = 8'hAA;
    localparam logic [15:0] IDLE_MAX         = 16'hFFFF;
    localparam int          MIN_FRAME_BYTES  = 3;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_READ    = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IGNORED  = 4'd0,
        ST_STORED   = 4'd1,
        ST_GOOD     = 4'd2,
        ST_BADSUM   = 4'd3,
        ST_BUSY     = 4'd4,
        ST_TICK     = 4'd5,
        ST_READ     = 4'd6,
        ST_RELEASED = 4'd7,
        ST_NONE     = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        CFG_FRAME_LENGTH = 2'd0,
        CFG_IDLE_LIMIT   = 2'd1,
        CFG_SYNC_VALUE   = 2'd2
    } t_cfg_index;

endpackage

>>> src/ufr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/uart_frame_receiver_unit.sv
// UART frame receiver: sync hunt, fixed-length frame capture, sum check, slot ring.
//
// Slave channel (i_s_*): one beat per event. tuser carries the operation
// (byte, millisecond tick, read pending byte, release pending frame); tdata
// carries the received byte and the read index.
// Master channel (o_m_*): exactly one result beat per input beat, in order.
// tuser carries the status code; tdata carries slot, read data, stale-drop
// flag and the count of frames pending.
// Config channel (i_cfg_*): index 0 frame length, 1 idle limit, 2 sync byte;
// o_cfg_ready is always high. Write only while no beat is in flight.
// Throughput: one beat per cycle sustained while the master side keeps taking
// results. A result passes the registered read of the frame store, then the
// output register.
// The two stages form a small pipeline; when the master side stalls, both
// stages fill and o_s_tready drops until the output beat is taken.
// Reset (synchronous, active low) returns the receiver to hunting, empties
// all slots and restores the register defaults; the frame store is not
// cleared and needs no clearing pass.
module uart_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [7:0] rx_byte, [12:8] read_index, [15:13] zero
    input  logic [1:0]  i_s_tuser,  // [1:0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [1:0] slot, [9:2] read_data, [10] stale_dropped,
                                    // [12:11] frames_pending, [15:13] zero
    output logic [3:0]  o_m_tuser,  // [3:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SW = ufr_pkg::SLOT_W;
    localparam int PW = ufr_pkg::POS_W;
    localparam int AW = ufr_pkg::ADDR_W;
    localparam int CW = ufr_pkg::CMP_W;

    // configuration
    logic [5:0]  r_frame_length;
    logic [15:0] r_idle_limit;
    logic [7:0]  r_sync_value;

    // receiver state
    logic                          r_in_frame,  n_in_frame;
    logic [PW-1:0]                 r_write_pos, n_write_pos;
    logic [7:0]                    r_sum,       n_sum;
    logic [15:0]                   r_idle,      n_idle;
    logic [ufr_pkg::SLOT_COUNT-1:0] r_slot_full, n_slot_full;
    logic [SW-1:0]                 r_fill_slot, n_fill_slot;
    logic [SW-1:0]                 r_drain_slot, n_drain_slot;

    // stage 1 and output stage
    logic             r_s1_valid;
    ufr_pkg::t_status r_s1_status;
    logic [SW-1:0]    r_s1_slot;
    logic             r_s1_rd_ok;
    logic             r_s1_stale;
    logic [1:0]       r_s1_pending;

    logic             r_o_valid;
    ufr_pkg::t_status r_o_status;
    logic [1:0]       r_o_slot;
    logic [7:0]       r_o_data;
    logic             r_o_stale;
    logic [1:0]       r_o_pending;

    // per-beat results
    ufr_pkg::t_status n_status;
    logic [SW-1:0]    n_slot;
    logic             n_rd_ok;
    logic             n_stale;
    logic [1:0]       n_pending;

    logic             s_acc, advance;
    ufr_pkg::t_op     in_op;
    logic [7:0]       in_byte;
    logic [4:0]       in_idx;
    logic [CW-1:0]    eff_len;
    logic             wr_en;
    logic [PW-1:0]    wr_pos;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [7:0]       rd_data;
    logic             stale_e;
    logic             in_frame_e;
    logic [PW-1:0]    pos_e;
    logic [PW-1:0]    pos_inc;

    assign advance    = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || advance;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign in_op   = ufr_pkg::t_op'(i_s_tuser);
    assign in_byte = i_s_tdata[7:0];
    assign in_idx  = i_s_tdata[12:8];

    // saturate the frame length into the legal range
    always_comb begin
        eff_len = CW'(r_frame_length);
        if (eff_len < CW'(ufr_pkg::MIN_FRAME_BYTES)) begin
            eff_len = CW'(ufr_pkg::MIN_FRAME_BYTES);
        end else if (eff_len > CW'(ufr_pkg::MAX_FRAME_BYTES)) begin
            eff_len = CW'(ufr_pkg::MAX_FRAME_BYTES);
        end
    end

    assign stale_e    = r_in_frame && (r_idle > r_idle_limit);
    assign in_frame_e = r_in_frame && !stale_e;
    assign pos_e      = stale_e ? '0 : r_write_pos;
    assign pos_inc    = pos_e + PW'(1);

    always_comb begin
        n_in_frame   = r_in_frame;
        n_write_pos  = r_write_pos;
        n_sum        = r_sum;
        n_idle       = r_idle;
        n_slot_full  = r_slot_full;
        n_fill_slot  = r_fill_slot;
        n_drain_slot = r_drain_slot;
        n_status     = ufr_pkg::ST_IGNORED;
        n_slot       = '0;
        n_rd_ok      = 1'b0;
        n_stale      = 1'b0;
        wr_en        = 1'b0;
        wr_pos       = '0;
        case (in_op)
            ufr_pkg::OP_BYTE: begin
                n_stale = stale_e;
                if (r_slot_full[r_fill_slot]) begin
                    // busy slot: back to hunting, silence count kept
                    n_in_frame  = 1'b0;
                    n_write_pos = '0;
                    n_sum       = '0;
                    n_status    = ufr_pkg::ST_BUSY;
                end else begin
                    n_idle = '0;
                    if (!in_frame_e) begin
                        n_in_frame  = 1'b0;
                        n_write_pos = '0;
                        n_sum       = '0;
                        if (in_byte == r_sync_value) begin
                            wr_en       = 1'b1;
                            n_write_pos = PW'(1);
                            n_in_frame  = 1'b1;
                            n_status    = ufr_pkg::ST_STORED;
                        end
                    end else if (CW'(pos_e) >= eff_len) begin
                        // frame length shrank under a partial frame
                        n_in_frame  = 1'b0;
                        n_write_pos = '0;
                        n_sum       = '0;
                    end else begin
                        wr_en  = 1'b1;
                        wr_pos = pos_e;
                        if (CW'(pos_inc) < eff_len) begin
                            n_write_pos = pos_inc;
                            n_sum       = r_sum + in_byte;
                            n_status    = ufr_pkg::ST_STORED;
                        end else begin
                            n_slot      = r_fill_slot;
                            n_in_frame  = 1'b0;
                            n_write_pos = '0;
                            n_sum       = '0;
                            if (r_sum != in_byte) begin
                                n_status = ufr_pkg::ST_BADSUM;
                            end else begin
                                n_status = ufr_pkg::ST_GOOD;
                                n_slot_full[r_fill_slot] = 1'b1;
                                if (r_fill_slot == SW'(ufr_pkg::SLOT_COUNT - 1)) begin
                                    n_fill_slot = '0;
                                end else begin
                                    n_fill_slot = r_fill_slot + SW'(1);
                                end
                            end
                        end
                    end
                end
            end
            ufr_pkg::OP_TICK: begin
                if (r_idle != ufr_pkg::IDLE_MAX) begin
                    n_idle = r_idle + 16'd1;
                end
                n_status = ufr_pkg::ST_TICK;
            end
            ufr_pkg::OP_READ: begin
                if (r_slot_full[r_drain_slot]) begin
                    n_status = ufr_pkg::ST_READ;
                    n_slot   = r_drain_slot;
                    n_rd_ok  = CW'(in_idx) < eff_len;
                end else begin
                    n_status = ufr_pkg::ST_NONE;
                end
            end
            ufr_pkg::OP_RELEASE: begin
                if (r_slot_full[r_drain_slot]) begin
                    n_status = ufr_pkg::ST_RELEASED;
                    n_slot   = r_drain_slot;
                    n_slot_full[r_drain_slot] = 1'b0;
                    if (r_drain_slot == SW'(ufr_pkg::SLOT_COUNT - 1)) begin
                        n_drain_slot = '0;
                    end else begin
                        n_drain_slot = r_drain_slot + SW'(1);
                    end
                end else begin
                    n_status = ufr_pkg::ST_NONE;
                end
            end
            default: begin
                n_status = ufr_pkg::ST_IGNORED;
            end
        endcase
        if ($countones(n_slot_full) > 3) begin
            n_pending = 2'd3;
        end else begin
            n_pending = 2'($countones(n_slot_full));
        end
    end

    assign wr_addr = AW'(r_fill_slot) * AW'(ufr_pkg::MAX_FRAME_BYTES) + AW'(wr_pos);
    assign rd_addr = AW'(r_drain_slot) * AW'(ufr_pkg::MAX_FRAME_BYTES)
                   + AW'(in_idx[ufr_pkg::IDX_W-1:0]);

    ufr_ram #(
        .WIDTH(8),
        .DEPTH(ufr_pkg::DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (s_acc && wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(in_byte),
        .i_rd_en  (s_acc && n_rd_ok),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= ufr_pkg::RST_FRAME_LENGTH;
            r_idle_limit   <= ufr_pkg::RST_IDLE_LIMIT;
            r_sync_value   <= ufr_pkg::RST_SYNC_VALUE;
        end else if (i_cfg_valid) begin
            case (ufr_pkg::t_cfg_index'(i_cfg_index))
                ufr_pkg::CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[5:0];
                ufr_pkg::CFG_IDLE_LIMIT:   r_idle_limit   <= i_cfg_data;
                ufr_pkg::CFG_SYNC_VALUE:   r_sync_value   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_write_pos  <= '0;
            r_sum        <= '0;
            r_idle       <= '0;
            r_slot_full  <= '0;
            r_fill_slot  <= '0;
            r_drain_slot <= '0;
        end else if (s_acc) begin
            r_in_frame   <= n_in_frame;
            r_write_pos  <= n_write_pos;
            r_sum        <= n_sum;
            r_idle       <= n_idle;
            r_slot_full  <= n_slot_full;
            r_fill_slot  <= n_fill_slot;
            r_drain_slot <= n_drain_slot;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= s_acc;
            end
            if (advance) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // pipeline payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_status  <= n_status;
            r_s1_slot    <= n_slot;
            r_s1_rd_ok   <= n_rd_ok;
            r_s1_stale   <= n_stale;
            r_s1_pending <= n_pending;
        end
        if (advance && r_s1_valid) begin
            r_o_status  <= r_s1_status;
            r_o_slot    <= 2'(r_s1_slot);
            r_o_data    <= r_s1_rd_ok ? rd_data : 8'd0;
            r_o_stale   <= r_s1_stale;
            r_o_pending <= r_s1_pending;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {3'b000, r_o_pending, r_o_stale, r_o_data, r_o_slot};

    // the store is never written into a slot that still holds a frame
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && wr_en) |-> !r_slot_full[r_fill_slot])
        else $error("frame store write into a full slot");

    // hunting keeps position and sum cleared; a frame in progress has its sync byte
    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_write_pos == '0 && r_sum == '0))
        else $error("hunting with stale position or sum");

    a_frame_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_write_pos != '0))
        else $error("frame in progress at position zero");

    // a good frame marks its slot full
    a_good_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && n_status == ufr_pkg::ST_GOOD) |=> r_slot_full[$past(r_fill_slot)])
        else $error("good frame left its slot empty");

    // a stalled stage 1 beat keeps its payload
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_status)
                                      && $stable(r_s1_slot)))
        else $error("stage 1 beat changed while stalled");

endmodule

>>> dv/tb_uart_frame_receiver_unit.sv
// Self-checking testbench for the UART frame receiver: framed traffic, stalls, register sweeps.
module tb_uart_frame_receiver_unit;
    import ufr_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 145;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx;
        logic [4:0] idx;
    } t_rx_event;

    typedef struct packed {
        t_status    status;
        logic [1:0] slot;
        logic [7:0] data;
        logic       stale;
        logic [1:0] pending;
    } t_rx_reply;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;   // [7:0] rx_byte, [12:8] read_index, [15:13] zero
    logic [1:0]  i_s_tuser   = '0;   // [1:0] operation
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;          // [1:0] slot, [9:2] read_data, [10] stale_dropped,
                                     // [12:11] frames_pending, [15:13] zero
    logic [3:0]  o_m_tuser;          // [3:0] status
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    uart_frame_receiver_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // receiver state mirror
    logic [5:0]  len_reg   = RST_FRAME_LENGTH;
    logic [15:0] idle_reg  = RST_IDLE_LIMIT;
    logic [7:0]  sync_reg  = RST_SYNC_VALUE;
    logic        in_frame_m = 1'b0;
    int          pos_m      = 0;
    logic [7:0]  sum_m      = 8'h00;
    logic [15:0] idle_m     = 16'h0000;
    logic [7:0]  frame_bytes [DEPTH];
    logic        slot_busy [SLOT_COUNT] = '{default: 1'b0};
    int          fill_ptr   = 0;
    int          drain_ptr  = 0;

    t_rx_event   rx_backlog[$];
    t_rx_reply   replies_due[$];
    bit          beat_taken   = 1'b0;
    bit          long_hold_go = 1'b0;
    int          quiet_cycles = 0;
    int          mismatches   = 0;

    // stimulus view of the current settings
    int          gen_len  = 12;
    int          gen_idle = 300;
    logic [7:0]  gen_sync = RST_SYNC_VALUE;

    function automatic void back_to_hunt();
        in_frame_m = 1'b0;
        pos_m      = 0;
        sum_m      = 8'h00;
    endfunction

    function automatic t_rx_reply advance_receiver(t_rx_event ev);
        t_rx_reply r;
        int        len;
        int        base;
        int        full_count;
        r = '0;
        r.status = ST_IGNORED;
        len = (len_reg < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES :
              (len_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(len_reg);
        base = fill_ptr * MAX_FRAME_BYTES;
        case (ev.op)
            OP_BYTE: begin
                // silence too long: discard the partial frame, then treat as hunting
                if (in_frame_m && idle_m > idle_reg) begin
                    back_to_hunt();
                    r.stale = 1'b1;
                end
                if (slot_busy[fill_ptr]) begin
                    back_to_hunt();
                    r.status = ST_BUSY;
                end else begin
                    idle_m = 16'h0000;
                    if (!in_frame_m) begin
                        if (ev.rx == sync_reg) begin
                            frame_bytes[base] = ev.rx;
                            pos_m      = 1;
                            sum_m      = 8'h00;
                            in_frame_m = 1'b1;
                            r.status   = ST_STORED;
                        end
                    end else if (pos_m >= len) begin
                        back_to_hunt();
                    end else begin
                        frame_bytes[base + pos_m] = ev.rx;
                        pos_m++;
                        if (pos_m < len) begin
                            sum_m    = sum_m + ev.rx;
                            r.status = ST_STORED;
                        end else begin
                            r.slot = 2'(fill_ptr);
                            if (sum_m != ev.rx) begin
                                r.status = ST_BADSUM;
                            end else begin
                                slot_busy[fill_ptr] = 1'b1;
                                fill_ptr = (fill_ptr + 1) % SLOT_COUNT;
                                r.status = ST_GOOD;
                            end
                            back_to_hunt();
                        end
                    end
                end
            end
            OP_TICK: begin
                if (idle_m != IDLE_MAX) idle_m++;
                r.status = ST_TICK;
            end
            OP_READ: begin
                if (slot_busy[drain_ptr]) begin
                    r.status = ST_READ;
                    r.slot   = 2'(drain_ptr);
                    if (ev.idx < len)
                        r.data = frame_bytes[drain_ptr * MAX_FRAME_BYTES + ev.idx];
                end else begin
                    r.status = ST_NONE;
                end
            end
            default: begin
                if (slot_busy[drain_ptr]) begin
                    r.status = ST_RELEASED;
                    r.slot   = 2'(drain_ptr);
                    slot_busy[drain_ptr] = 1'b0;
                    drain_ptr = (drain_ptr + 1) % SLOT_COUNT;
                end else begin
                    r.status = ST_NONE;
                end
            end
        endcase
        full_count = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
            if (slot_busy[s]) full_count++;
        r.pending = 2'((full_count > 3) ? 3 : full_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        // keep the log short on a badly broken build
        if (mismatches < 40)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // input and output beats, register writes, quiet-cycle count
    always @(posedge i_clk) begin : watch
        t_rx_event ev;
        t_rx_reply want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_m_tvalid && i_m_tready) begin
                quiet_cycles = 0;
                if (replies_due.size() == 0) begin
                    report_mismatch("result beat with none due, status", 16'(o_m_tuser), '1);
                end else begin
                    want = replies_due.pop_front();
                    if (o_m_tuser !== want.status)
                        report_mismatch("status", 16'(o_m_tuser), 16'(want.status));
                    if (o_m_tdata[1:0] !== want.slot)
                        report_mismatch("slot", 16'(o_m_tdata[1:0]), 16'(want.slot));
                    if (o_m_tdata[9:2] !== want.data)
                        report_mismatch("read_data", 16'(o_m_tdata[9:2]), 16'(want.data));
                    if (o_m_tdata[10] !== want.stale)
                        report_mismatch("stale_dropped", 16'(o_m_tdata[10]), 16'(want.stale));
                    if (o_m_tdata[12:11] !== want.pending)
                        report_mismatch("frames_pending", 16'(o_m_tdata[12:11]),
                                        16'(want.pending));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                quiet_cycles = 0;
                ev.op  = t_op'(i_s_tuser);
                ev.rx  = i_s_tdata[7:0];
                ev.idx = i_s_tdata[12:8];
                replies_due.push_back(advance_receiver(ev));
                beat_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                quiet_cycles = 0;
                case (i_cfg_index)
                    CFG_FRAME_LENGTH: len_reg  = i_cfg_data[5:0];
                    CFG_IDLE_LIMIT:   idle_reg = i_cfg_data;
                    CFG_SYNC_VALUE:   sync_reg = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // sender: bursts of beats with random gaps between them
    always @(negedge i_clk) begin : feed
        int         burst_left;
        int         gap_left;
        logic       v;
        logic [15:0] d;
        logic [1:0] u;
        t_rx_event  ev;
        v = i_s_tvalid;
        d = i_s_tdata;
        u = i_s_tuser;
        if (!i_s_tvalid || beat_taken) begin
            beat_taken = 1'b0;
            v = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (rx_backlog.size() > 0) begin
                ev = rx_backlog.pop_front();
                v  = 1'b1;
                d  = {3'b000, ev.idx, ev.rx};
                u  = ev.op;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
        i_s_tvalid <= v;
        i_s_tdata  <= d;
        i_s_tuser  <= u;
    end

    // receiver: stall pattern in segments, plus one long hold-off on request
    always @(negedge i_clk) begin : take
        int   seg_left;
        int   stall_mode;
        int   hold_left;
        logic r;
        if (long_hold_go) begin
            long_hold_go = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (seg_left == 0) begin
            seg_left   = $urandom_range(4, 60);
            stall_mode = $urandom_range(0, 3);
        end else begin
            seg_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
        end else begin
            case (stall_mode)
                0:       r = 1'b1;
                1:       r = 1'($urandom_range(0, 1));
                2:       r = ($urandom_range(0, 3) == 0);
                default: r = ($urandom_range(0, 4) != 0);
            endcase
        end
        i_m_tready <= r;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("** uart_frame_receiver_unit: FAILED **");
        $finish;
    end

    task automatic queue_event(t_op op, logic [7:0] rx, logic [4:0] idx);
        t_rx_event ev;
        ev.op  = op;
        ev.rx  = rx;
        ev.idx = idx;
        rx_backlog.push_back(ev);
    endtask

    task automatic queue_ticks(int n);
        for (int k = 0; k < n; k++)
            queue_event(OP_TICK, 8'($urandom), 5'($urandom));
    endtask

    // sync plus keep-1 further bytes; a full-length frame ends in its checksum
    task automatic queue_frame(int keep, bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        queue_event(OP_BYTE, gen_sync, 5'($urandom));
        for (int k = 1; k < keep; k++) begin
            if ($urandom_range(0, 7) == 0) queue_ticks($urandom_range(1, 3));
            if (k == gen_len - 1) begin
                b = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
            end else begin
                b   = 8'($urandom);
                sum = sum + b;
            end
            queue_event(OP_BYTE, b, 5'($urandom));
        end
    endtask

    task automatic queue_read();
        logic [4:0] idx;
        idx = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, gen_len - 1));
        queue_event(OP_READ, 8'($urandom), idx);
    endtask

    // queue at least n beats; the backlog grows in zero time, so its size counts them
    task automatic queue_random_traffic(int n);
        int start;
        int pick;
        int cut;
        start = rx_backlog.size();
        while (rx_backlog.size() - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                queue_frame(gen_len, 1'b0);
            end else if (pick < 52) begin
                queue_frame(gen_len, 1'b1);
            end else if (pick < 60) begin
                // cut a frame short, then tick about the idle limit if it is under 40, else one to four times
                cut = $urandom_range(1, gen_len - 1);
                queue_frame(cut, 1'b0);
                if (gen_idle < 40) queue_ticks(gen_idle + $urandom_range(0, 2));
                else queue_ticks($urandom_range(1, 4));
            end else if (pick < 64) begin
                queue_ticks($urandom_range(1, 6));
            end else if (pick < 78) begin
                queue_read();
            end else if (pick < 91) begin
                queue_event(OP_RELEASE, 8'($urandom), 5'($urandom));
            end else begin
                queue_event(OP_BYTE, 8'($urandom), 5'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (rx_backlog.size() != 0 || i_s_tvalid || replies_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // empty every slot so a later longer frame never reads unwritten bytes;
    // leave a partial frame behind to meet the next settings
    task automatic close_phase();
        repeat (SLOT_COUNT) queue_event(OP_RELEASE, 8'($urandom), 5'($urandom));
        queue_frame($urandom_range(1, gen_len - 1), 1'b0);
        wait_drained();
    endtask

    task automatic write_register(t_cfg_index idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
    endtask

    task automatic apply_settings(logic [5:0] len, logic [15:0] idle, logic [7:0] sync);
        write_register(CFG_FRAME_LENGTH, {10'($urandom), len});
        write_register(CFG_IDLE_LIMIT, idle);
        write_register(CFG_SYNC_VALUE, {8'($urandom), sync});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_len  = (len < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES :
                   (len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(len);
        gen_idle = int'(idle);
        gen_sync = sync;
    endtask

    initial begin : run
        logic [7:0] sum;
        logic [7:0] b;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass on reset settings: one good frame, reads, releases, tick, noise
        sum = 8'h00;
        queue_event(OP_BYTE, RST_SYNC_VALUE, 5'd31);
        for (int k = 1; k <= 10; k++) begin
            b   = (k == 1) ? 8'h00 : (k == 2) ? 8'hFF : 8'($urandom);
            sum = sum + b;
            queue_event(OP_BYTE, b, 5'($urandom));
        end
        queue_event(OP_BYTE, sum, 5'd0);
        queue_event(OP_READ, 8'h00, 5'd0);
        queue_event(OP_READ, 8'hFF, 5'd11);
        queue_event(OP_READ, 8'h00, 5'd31);
        queue_event(OP_RELEASE, 8'h00, 5'd0);
        queue_event(OP_RELEASE, 8'hFF, 5'd31);
        queue_event(OP_READ, 8'h00, 5'd0);
        queue_event(OP_TICK, 8'hFF, 5'd31);
        queue_event(OP_BYTE, 8'h55, 5'd0);
        wait_drained();
        close_phase();

        for (int p = 1; p <= PHASES; p++) begin
            case (p)
                1:       apply_settings(6'd3, 16'd0, 8'h00);
                2:       apply_settings(6'd32, 16'hFFFF, 8'hFF);
                3:       apply_settings(6'd0, 16'd2, 8'($urandom));
                4:       apply_settings(6'd63, 16'd1, 8'($urandom));
                5:       apply_settings(6'd2, 16'd5, 8'($urandom));
                6:       apply_settings(6'd33, 16'd300, 8'($urandom));
                default: apply_settings(6'($urandom),
                                        ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                    : 16'($urandom_range(0, 12)),
                                        8'($urandom));
            endcase
            queue_random_traffic(PHASE_ITEMS);
            // hold the result side off while the sender keeps pushing
            if (p == 1) long_hold_go = 1'b1;
            close_phase();
        end

        repeat (10) @(posedge i_clk);
        if (replies_due.size() != 0)
            report_mismatch("results still due at end", 16'(replies_due.size()), 16'd0);
        if (mismatches == 0)
            $display("** uart_frame_receiver_unit: PASSED **");
        else
            $display("** uart_frame_receiver_unit: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
src/ufr_pkg.sv
src/ufr_ram.sv
src/uart_frame_receiver_unit.sv
dv/tb_uart_frame_receiver_unit.sv
